/* sv/chte_pkg.sv */
package chte_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_HEAD,
    ST_HEADW,
    ST_CHK,
    ST_ENTW,
    ST_ACT,
    ST_SCAN,
    ST_SCANW,
    ST_DONE
  } state_t;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_GET    = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;
  localparam logic [1:0] FN_NOP    = 2'd3;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  localparam logic [1:0] CFG_KEY_BYTES   = 2'd0;
  localparam logic [1:0] CFG_VALUE_BYTES = 2'd1;

  localparam logic [63:0] HASH_SEED = 64'd5381;
  localparam logic [63:0] HASH_MUL  = 64'd33;
  localparam logic [3:0]  MAX_BYTES = 4'd8;

  function automatic logic [3:0] clamp_bytes(input logic [3:0] n);
    return (n > MAX_BYTES) ? MAX_BYTES : n;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i*8 +: 8] = {8{(4'(i) < n)}};
    end
    return m;
  endfunction

endpackage

/* sv/chained_hash_table_engine.sv */
// channel | direction | ports
// in      | in        | in_valid, in_ready, in_func, in_key, in_value
// out     | out       | out_valid, out_ready, out_status, out_data
// cfg     | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
// One word at a time, in steps: accept, hash over the key bytes, modulo reduction when
// BUCKETS is not a power of two, head read, a read of each chain entry visited through
// the registered-read entry memory, a final check at the chain end on a miss, update
// and output. A no-op goes from accept straight to output. An insert of a new key, when
// the pool is not full, then scans the entries after it for the next free one.
// After reset a clearing pass over all head and entry-use words holds in_ready low.
// A result waiting on out_ready holds the next word in the output cycle; cfg_ready is
// always high.
module chained_hash_table_engine
  import chte_pkg::*;
#(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW    = $clog2(ENTRIES + 1);
  localparam int CLR_N = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam bit BKT_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [BW-1:0] BMASK  = BW'(BUCKETS - 1);
  localparam logic [31:0]   BKT32  = 32'(BUCKETS);
  localparam logic [31:0]   RECIP  = 32'((64'd1 << 32) / 64'(BUCKETS));
  localparam logic [LW-1:0] ENT_LW = LW'(ENTRIES);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);

  typedef struct packed {
    logic [63:0]   key;
    logic [63:0]   val;
    logic [LW-1:0] link;
  } ent_t;

  logic [LW-1:0] head_mem [BUCKETS];
  ent_t          ent_mem  [ENTRIES];
  logic          used_mem [ENTRIES];

  logic          head_we, ent_we, used_we, used_wd;
  logic [BW-1:0] head_wa, head_ra;
  logic [LW-1:0] head_wd;
  logic [IW-1:0] ent_wa, ent_ra, used_wa, used_ra;
  ent_t          ent_wd;
  logic [LW-1:0] head_rd_r;
  ent_t          ent_rd_r;
  logic          used_rd_r;

  state_t        state_r, state_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [3:0]    kb_cfg_r, vb_cfg_r;
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] ucnt_r, ucnt_nxt, lf_r, lf_nxt;

  logic [1:0]    func_r, func_nxt, sts_r, sts_nxt;
  logic [63:0]   key_r, key_nxt, ksh_r, ksh_nxt, val_r, val_nxt;
  logic [63:0]   h_r, h_nxt, vout_r, vout_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [31:0]   mod_x, mod_q, mod_t;
  logic [BW-1:0] bkt_r, bkt_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, hv_r, hv_nxt;
  ent_t          fnd_r, fnd_nxt, prv_r, prv_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [63:0]   out_value_r, out_value_nxt;

  logic [3:0]    kb;
  logic [63:0]   km, vm;
  logic [LW-1:0] cm1, pm1;
  logic          hit, full, done_go;

  assign kb        = clamp_bytes(kb_cfg_r);
  assign km        = byte_mask(kb);
  assign vm        = byte_mask(clamp_bytes(vb_cfg_r));
  assign cm1       = cur_r - LW'(1);
  assign pm1       = prev_r - LW'(1);
  assign hit       = (ent_rd_r.key & km) == key_r;
  assign full      = ucnt_r == ENT_LW;
  assign done_go   = !out_valid_r || out_ready;
  assign mod_x     = {rem_r, h_r[63:48]};
  assign mod_q     = prod_r[63:32];
  assign mod_t     = mod_x - mod_q * BKT32;
  assign cfg_ready = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_value_r;

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_rd_r <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_rd_r <= used_mem[used_ra];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == FN_NOP) ? ST_DONE : ST_HASH;
        end
      end
      ST_HASH: begin
        if (cnt_r[3:0] >= kb) begin
          state_nxt = BKT_POW2 ? ST_HEAD : ST_MOD;
        end
      end
      ST_MOD:   if (cnt_r == 7'd7) state_nxt = ST_HEAD;
      ST_HEAD:  state_nxt = ST_HEADW;
      ST_HEADW: state_nxt = ST_CHK;
      ST_CHK:   state_nxt = (cur_r != '0) ? ST_ENTW : ST_ACT;
      ST_ENTW:  state_nxt = hit ? ST_ACT : ST_CHK;
      ST_ACT: begin
        state_nxt = ST_DONE;
        if (func_r == FN_INSERT && cur_r == '0 && !full) state_nxt = ST_SCAN;
      end
      ST_SCAN:  state_nxt = (lf_r == ENT_LW) ? ST_DONE : ST_SCANW;
      ST_SCANW: state_nxt = used_rd_r ? ST_SCAN : ST_DONE;
      ST_DONE:  if (done_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    clr_nxt = clr_r;
    ucnt_nxt = ucnt_r;
    lf_nxt = lf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt = out_value_r;
    func_nxt = func_r;
    sts_nxt = sts_r;
    key_nxt = key_r;
    ksh_nxt = ksh_r;
    val_nxt = val_r;
    h_nxt = h_r;
    vout_nxt = vout_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    prod_nxt = prod_r;
    bkt_nxt = bkt_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    hv_nxt = hv_r;
    fnd_nxt = fnd_r;
    prv_nxt = prv_r;
    head_we = 1'b0;
    head_wa = bkt_r;
    head_wd = '0;
    head_ra = bkt_r;
    ent_we = 1'b0;
    ent_wa = lf_r[IW-1:0];
    ent_wd = '{key: key_r, val: val_r, link: hv_r};
    ent_ra = cm1[IW-1:0];
    used_we = 1'b0;
    used_wa = lf_r[IW-1:0];
    used_wd = 1'b0;
    used_ra = lf_r[IW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        head_we = 32'(clr_r) < BUCKETS;
        head_wa = BW'(clr_r);
        used_we = 32'(clr_r) < ENTRIES;
        used_wa = IW'(clr_r);
        clr_nxt = clr_r + CW'(1);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt = in_func;
          key_nxt = in_key & km;
          ksh_nxt = in_key & km;
          val_nxt = in_value & vm;
          h_nxt = HASH_SEED;
          cnt_nxt = '0;
          rem_nxt = '0;
          prev_nxt = '0;
          sts_nxt = STS_OK;
          vout_nxt = '0;
        end
      end
      ST_HASH: begin
        if (cnt_r[3:0] < kb) begin
          h_nxt = h_r * HASH_MUL + {56'd0, ksh_r[7:0]};
          ksh_nxt = ksh_r >> 8;
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          cnt_nxt = '0;
          bkt_nxt = h_r[BW-1:0] & BMASK;
        end
      end
      ST_MOD: begin
        if (!cnt_r[0]) begin
          prod_nxt = 64'(mod_x) * 64'(RECIP);
        end else begin
          rem_nxt = (mod_t >= BKT32) ? 16'(mod_t - BKT32) : mod_t[15:0];
          h_nxt = h_r << 16;
        end
        cnt_nxt = cnt_r + 7'd1;
        bkt_nxt = rem_nxt[BW-1:0];
      end
      ST_HEADW: begin
        cur_nxt = head_rd_r;
        hv_nxt = head_rd_r;
      end
      ST_ENTW: begin
        if (hit) begin
          fnd_nxt = ent_rd_r;
        end else begin
          prev_nxt = cur_r;
          prv_nxt = ent_rd_r;
          cur_nxt = ent_rd_r.link;
        end
      end
      ST_ACT: begin
        priority case (func_r)
          FN_INSERT: begin
            if (cur_r != '0) begin
              ent_we = 1'b1;
              ent_wa = cm1[IW-1:0];
              ent_wd = '{key: fnd_r.key, val: val_r, link: fnd_r.link};
            end else if (full) begin
              sts_nxt = STS_FULL;
            end else begin
              ent_we = 1'b1;
              head_we = 1'b1;
              head_wd = lf_r + LW'(1);
              used_we = 1'b1;
              used_wd = 1'b1;
              ucnt_nxt = ucnt_r + LW'(1);
              lf_nxt = lf_r + LW'(1);
            end
          end
          FN_GET: begin
            if (cur_r != '0) vout_nxt = fnd_r.val & vm;
            else sts_nxt = STS_MISS;
          end
          default: begin
            if (cur_r != '0) begin
              if (prev_r == '0) begin
                head_we = 1'b1;
                head_wd = fnd_r.link;
              end else begin
                ent_we = 1'b1;
                ent_wa = pm1[IW-1:0];
                ent_wd = '{key: prv_r.key, val: prv_r.val, link: fnd_r.link};
              end
              used_we = 1'b1;
              used_wa = cm1[IW-1:0];
              ucnt_nxt = ucnt_r - LW'(1);
              if (cm1 < lf_r) lf_nxt = cm1;
            end else begin
              sts_nxt = STS_MISS;
            end
          end
        endcase
      end
      ST_SCANW: if (used_rd_r) lf_nxt = lf_r + LW'(1);
      ST_DONE: begin
        if (done_go) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = sts_r;
          out_value_nxt = vout_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      kb_cfg_r <= MAX_BYTES;
      vb_cfg_r <= MAX_BYTES;
      out_valid_r <= 1'b0;
      ucnt_r <= '0;
      lf_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      ucnt_r <= ucnt_nxt;
      lf_r <= lf_nxt;
      if (cfg_valid && cfg_index == CFG_KEY_BYTES) kb_cfg_r <= cfg_data;
      if (cfg_valid && cfg_index == CFG_VALUE_BYTES) vb_cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    sts_r <= sts_nxt;
    key_r <= key_nxt;
    ksh_r <= ksh_nxt;
    val_r <= val_nxt;
    h_r <= h_nxt;
    vout_r <= vout_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    prod_r <= prod_nxt;
    bkt_r <= bkt_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    hv_r <= hv_nxt;
    fnd_r <= fnd_nxt;
    prv_r <= prv_nxt;
    out_status_r <= out_status_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef ASSERT_OFF
  a_ucnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ucnt_r <= ENT_LW) else $error("used count above pool size");
  a_lf_range: assert property (@(posedge clk) disable iff (!rst_n)
    lf_r <= ENT_LW) else $error("free hint above pool size");
  a_free_hint: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !full) |-> lf_r < ENT_LW)
    else $error("free entry exists but hint is past the pool");
  a_no_alloc_full: assert property (@(posedge clk) disable iff (!rst_n)
    (used_we && used_wd) |-> (state_r == ST_ACT && !full))
    else $error("entry allocated while pool full");
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && done_go) |=> out_valid_r)
    else $error("result not presented");
`endif

endmodule

/* dv/testbench.sv */
module testbench;
  import chte_pkg::*;

  class table_scoreboard;
    bit [7:0]  head[256];
    bit [63:0] ekey[128];
    bit [63:0] eval[128];
    bit [7:0]  elink[128];
    bit        used[128];
    bit [3:0]  key_bytes;
    bit [3:0]  value_bytes;
    bit [1:0]  status_q[$];
    bit [63:0] value_q[$];
    int        errors;

    function void clear();
      foreach (head[i]) head[i] = 0;
      foreach (used[i]) used[i] = 0;
      key_bytes = 8;
      value_bytes = 8;
      errors = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [3:0] data);
      if (idx == CFG_KEY_BYTES) key_bytes = data;
      else if (idx == CFG_VALUE_BYTES) value_bytes = data;
    endfunction

    function bit [63:0] mask_of(bit [3:0] n);
      bit [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) if (i < n) m[i*8 +: 8] = 8'hff;
      return m;
    endfunction

    function void note(bit [1:0] fn, bit [63:0] key, bit [63:0] value);
      bit [63:0] km, vm, k, h, vout;
      bit [3:0]  kb;
      bit [7:0]  b, prev, cur, found;
      bit [1:0]  st;
      int        steps, i;
      kb = (key_bytes > 8) ? 4'd8 : key_bytes;
      km = mask_of(kb);
      vm = mask_of((value_bytes > 8) ? 4'd8 : value_bytes);
      k = key & km;
      h = 64'd5381;
      for (i = 0; i < kb; i++) h = h * 64'd33 + 64'(k[i*8 +: 8]);
      b = h[7:0];
      prev = 0;
      cur = head[b];
      found = 0;
      steps = 0;
      st = STS_OK;
      vout = '0;
      while (cur != 0 && cur <= 128 && steps < 128) begin
        if ((ekey[cur-1] & km) == k) begin
          found = cur;
          break;
        end
        prev = cur;
        cur = elink[cur-1];
        steps++;
      end
      case (fn)
        FN_INSERT: begin
          if (found != 0) begin
            eval[found-1] = value & vm;
          end else begin
            for (i = 0; i < 128 && used[i]; i++) ;
            if (i >= 128) begin
              st = STS_FULL;
            end else begin
              used[i] = 1;
              ekey[i] = k;
              eval[i] = value & vm;
              elink[i] = head[b];
              head[b] = 8'(i + 1);
            end
          end
        end
        FN_GET: begin
          if (found != 0) vout = eval[found-1] & vm;
          else st = STS_MISS;
        end
        FN_REMOVE: begin
          if (found != 0) begin
            if (prev == 0) head[b] = elink[found-1];
            else elink[prev-1] = elink[found-1];
            used[found-1] = 0;
          end else begin
            st = STS_MISS;
          end
        end
        default: ;
      endcase
      status_q.push_back(st);
      value_q.push_back(vout);
    endfunction

    function void check(bit [1:0] status, bit [63:0] vout);
      bit [1:0]  es;
      bit [63:0] ev;
      if (status_q.size() == 0) begin
        $error("unexpected result word: status %0d data %h", status, vout);
        errors++;
        return;
      end
      es = status_q.pop_front();
      ev = value_q.pop_front();
      if (es != status) begin
        $error("status: expected %0d actual %0d", es, status);
        errors++;
      end
      if (ev != vout) begin
        $error("data: expected %h actual %h", ev, vout);
        errors++;
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [63:0] in_key;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [63:0] out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  table_scoreboard sb;
  int        send_idle;
  int        recv_idle;
  int        hold_cycles;
  bit [63:0] key_pool[256];

  chained_hash_table_engine DUT (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_status, out_data);
  end

  task automatic send_word(bit [1:0] fn, bit [63:0] key, bit [63:0] value);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_key <= key;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(fn, key, value);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [3:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    bit [3:0]  kb_set[9] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd8, 4'd2, 4'd3, 4'd8};
    bit [3:0]  vb_set[9] = '{4'd8, 4'd3, 4'd0, 4'd12, 4'd8, 4'd1, 4'd7, 4'd5, 4'd9};
    int        set_size[9] = '{200, 24, 8, 160, 40, 220, 16, 64, 180};
    int        ins_pct;
    int        r;
    bit [1:0]  fn;
    bit [63:0] key;
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_key = '0;
    in_value = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 11;
    recv_idle = 86;
    hold_cycles = 0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(FN_GET, 64'd0, 64'd0);
    send_word(FN_INSERT, 64'd0, 64'hffff_ffff_ffff_ffff);
    send_word(FN_INSERT, 64'hffff_ffff_ffff_ffff, 64'd0);
    send_word(FN_GET, 64'd0, 64'd0);
    send_word(FN_GET, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_word(FN_INSERT, 64'd0, 64'h8000_0000_0000_0001);
    send_word(FN_GET, 64'd0, 64'd0);
    send_word(FN_NOP, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_word(FN_REMOVE, 64'd0, 64'd0);
    send_word(FN_REMOVE, 64'd0, 64'd0);
    send_word(FN_GET, 64'd0, 64'd0);
    send_word(FN_REMOVE, 64'hffff_ffff_ffff_ffff, 64'd0);
    send_word(FN_INSERT, 64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321);
    send_word(FN_GET, 64'h1234_5678_9abc_def0, 64'd0);
    send_word(FN_REMOVE, 64'h1234_5678_9abc_def0, 64'd0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_KEY_BYTES, kb_set[ph]);
      write_reg(CFG_VALUE_BYTES, vb_set[ph]);
      if (ph < 3) begin
        send_idle = 11;
        recv_idle = 86;
      end else if (ph < 6) begin
        send_idle = 86;
        recv_idle = 11;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      ins_pct = (ph == 0 || ph == 5) ? 80 : 45;
      if (ph == 6) hold_cycles = 3000;
      for (int n = 0; n < 200; n++) begin
        if (ph == 4 && n == 100) drain();
        r = $urandom_range(99, 0);
        if (r < ins_pct) fn = FN_INSERT;
        else if (r < ins_pct + (100 - ins_pct) / 2) fn = FN_GET;
        else if (r < 95) fn = FN_REMOVE;
        else fn = FN_NOP;
        if ($urandom_range(9, 0) == 0) key = {$urandom, $urandom};
        else key = key_pool[$urandom_range(set_size[ph] - 1, 0)];
        send_word(fn, key, {$urandom, $urandom});
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
